/* rtl/pilot_smoother_edge_renorm_assert.svh */
// Assertion macros shared by the pilot smoother RTL.
`ifndef PILOT_SMOOTHER_EDGE_RENORM_ASSERT_SVH
`define PILOT_SMOOTHER_EDGE_RENORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSER_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSER_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pser_pkg.sv */
// Constants and helpers for the pilot smoother with renormalised band edges.
package pser_pkg;

    localparam int DEF_MAX_TAPS  = 16;
    localparam int SAMPLE_W      = 16;
    localparam int TAP_W         = 16;
    localparam int PROD_W        = 2 * SAMPLE_W;
    localparam int ACC_W         = 36;
    localparam int NORM_W        = 21;
    localparam int NUM_W         = 37;
    localparam int DIVC_W        = $clog2(NUM_W);
    localparam int FRAC_BITS     = 14;
    localparam int INT_ROUND     = 1 << (FRAC_BITS - 1);
    localparam int NUM_REG_TAPS  = 16;
    localparam int NUM_TAP_WORDS = 4;
    localparam int TAP_COUNT_W   = 5;
    localparam int IDX_W         = 5;
    localparam int INDEX_CAP     = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int SAT_POS       = 32767;
    localparam int SAT_NEG_MAG   = 32768;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_3    = 3'd4;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 5'd1;
    localparam logic [CFG_DATA_W-1:0]  TAPS_0_RST    = 64'd16384;
    localparam logic [CFG_DATA_W-1:0]  TAPS_N_RST    = 64'd0;

    // Apply sign to a rounded magnitude and saturate to 16 bits.
    function automatic logic [SAMPLE_W-1:0] sat16(input logic neg,
                                                  input logic [NUM_W-1:0] q);
        if (!neg) begin
            return (q > NUM_W'(SAT_POS)) ? 16'h7FFF : q[SAMPLE_W-1:0];
        end
        return (q > NUM_W'(SAT_NEG_MAG)) ? 16'h8000 : (~q[SAMPLE_W-1:0] + 16'd1);
    endfunction

endpackage

/* rtl/pilot_smoother_edge_renorm.sv */
// Pilot smoother: real FIR over complex pilots with renormalised band edges.
//
// Usage
//   s_ channel: one pilot per transfer. s_tdata[15:0] is the real part,
//   s_tdata[31:16] the imaginary part; s_tlast marks the last pilot of a band.
//   m_ channel: one smoothed pilot per transfer, same packing; m_tlast marks
//   the final result of the band. Pilot i comes out once pilot i+M/2 is in;
//   the pilot marked last flushes every outstanding result of the band.
//   cfg_ port: write tap count (index 0) and the four tap words (1..4) while
//   the block is idle; writes land on the clock edge with cfg_we high.
// Timing
//   Samples sit in a circular window memory with a registered read. Each result
//   runs a single shared complex MAC over the M taps, then rounding set-up in
//   the ABS and PREP steps. Interior results round by shift; edge results with
//   a positive tap sum go through a 37-step restoring divider (one quotient bit
//   per cycle) for each of I and Q in parallel; other edge results pass the
//   centre sample through. s_tready returns once the last result of a transfer
//   loads into the output register; a band end runs the same sequence for each
//   flushed result. s_tready is high only while the sequencer is idle.
// Reset and stall
//   aresetn (synchronous, active low) restores the power-up taps (single tap of
//   1.0) and starts a fresh band; the window memory is not cleared. A held
//   result waits in the output register; the sequencer holds in its emit step
//   until that register frees up, so a stalled receiver stalls input too.
`include "pilot_smoother_edge_renorm_assert.svh"

module pilot_smoother_edge_renorm
    import pser_pkg::*;
#(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pilots
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // [15:0] sample_re, [31:16] sample_im
    input  logic                  s_tlast,    // band_end
    // smoothed pilots
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [15:0] smooth_re, [31:16] smooth_im
    output logic                  m_tlast,    // band_done
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WIN_DEPTH = MAX_TAPS + 1;
    localparam int ADDR_W    = $clog2(WIN_DEPTH);
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CNT_W     = $clog2(MAX_TAPS + 2);
    localparam int OFF_W     = CNT_W + 2;
    localparam int DVS_W     = NORM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ABS,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic [CFG_DATA_W-1:0]  taps_word_reg [NUM_TAP_WORDS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg    <= TAP_COUNT_RST;
            taps_word_reg[0] <= TAPS_0_RST;
            taps_word_reg[1] <= TAPS_N_RST;
            taps_word_reg[2] <= TAPS_N_RST;
            taps_word_reg[3] <= TAPS_N_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TAP_COUNT: tap_count_reg    <= cfg_wdata[TAP_COUNT_W-1:0];
                REG_TAPS_0:    taps_word_reg[0] <= cfg_wdata;
                REG_TAPS_1:    taps_word_reg[1] <= cfg_wdata;
                REG_TAPS_2:    taps_word_reg[2] <= cfg_wdata;
                REG_TAPS_3:    taps_word_reg[3] <= cfg_wdata;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Clamp the tap count to 1..MAX_TAPS; h is the centre offset.
    logic [CNT_W-1:0] m_eff;
    logic [CNT_W-1:0] h_eff;

    always_comb begin
        if (tap_count_reg == '0) begin
            m_eff = CNT_W'(1);
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            m_eff = CNT_W'(MAX_TAPS);
        end else begin
            m_eff = CNT_W'(tap_count_reg);
        end
        h_eff = m_eff >> 1;
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t                    state_reg;
    logic [ADDR_W-1:0]         wp_reg;        // address of the newest sample
    logic [IDX_W-1:0]          idx_reg;       // samples seen in this band, capped
    logic [IDX_W-1:0]          j_reg;         // index of the newest sample
    logic                      last_reg;
    logic [CNT_W-1:0]          mtap_reg;
    logic [CNT_W-1:0]          h_reg;
    logic [CNT_W-1:0]          d_reg;         // newest index minus output index
    logic [CNT_W-1:0]          m_cnt_reg;

    logic                      p1_valid_reg;
    logic                      p1_cap_reg;
    logic signed [TAP_W-1:0]   p1_tap_reg;
    logic                      p2_valid_reg;
    logic signed [TAP_W-1:0]   p2_tap_reg;
    logic signed [PROD_W-1:0]  p2_re_reg;
    logic signed [PROD_W-1:0]  p2_im_reg;

    logic signed [ACC_W-1:0]   acc_re_reg;
    logic signed [ACC_W-1:0]   acc_im_reg;
    logic signed [NORM_W-1:0]  norm_reg;
    logic [31:0]               pass_reg;

    logic [ACC_W-1:0]          mag_re_reg;
    logic [ACC_W-1:0]          mag_im_reg;
    logic                      neg_re_reg;
    logic                      neg_im_reg;
    logic                      use_pass_reg;

    logic [NUM_W-1:0]          num_re_reg;    // numerator, becomes the quotient
    logic [NUM_W-1:0]          num_im_reg;
    logic [DVS_W-1:0]          rem_re_reg;
    logic [DVS_W-1:0]          rem_im_reg;
    logic [DVS_W-1:0]          dvs_reg;
    logic [DIVC_W-1:0]         div_cnt_reg;

    logic                      m_tvalid_reg;
    logic [31:0]               m_data_reg;
    logic                      m_last_reg;

    // ------------------------------------------------------------------
    // Handshake and window addressing
    // ------------------------------------------------------------------
    logic                      in_xfer;
    logic [ADDR_W-1:0]         wp_next;
    logic [IDX_W-1:0]          idx_next;
    logic signed [OFF_W-1:0]   off_s;
    logic                      issue_ok;
    logic                      cap_now;
    logic [ADDR_W-1:0]         rd_addr;
    logic [3:0]                tap_sel;
    logic signed [TAP_W-1:0]   tap_now;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign wp_next  = wp_reg + ADDR_W'(1);

    always_comb begin
        if (s_tlast) begin
            idx_next = '0;
        end else if (int'(idx_reg) >= INDEX_CAP) begin
            idx_next = idx_reg;
        end else begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Tap m reads window entry d+h-m counted back from the newest sample;
    // drop taps that land after the newest sample or before the band start.
    assign off_s = $signed({2'b00, d_reg}) + $signed({2'b00, h_reg})
                 - $signed({2'b00, m_cnt_reg});
    assign issue_ok = (state_reg == ST_MAC) && (m_cnt_reg < mtap_reg)
                   && !off_s[OFF_W-1] && (int'(off_s) <= int'(j_reg));
    // Tap h always sits on the output's own sample: keep it for pass-through.
    assign cap_now = (state_reg == ST_MAC) && (m_cnt_reg == h_reg);
    assign rd_addr = wp_reg - off_s[ADDR_W-1:0];

    always_comb begin
        tap_sel = 4'(m_cnt_reg);
        if (int'(m_cnt_reg) < NUM_REG_TAPS) begin
            tap_now = $signed(taps_word_reg[tap_sel[3:2]][{tap_sel[1:0], 4'b0000} +: TAP_W]);
        end else begin
            tap_now = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sample window memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [31:0] win_mem [MEM_DEPTH];
    logic [31:0] win_rdata_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            win_mem[wp_next] <= s_tdata;
        end
        win_rdata_reg <= win_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Rounding and division datapath
    // ------------------------------------------------------------------
    logic                  interior;
    logic                  norm_pos;
    logic [DVS_W:0]        rem_re_sh;
    logic [DVS_W:0]        rem_im_sh;
    logic                  re_ge;
    logic                  im_ge;
    logic [DVS_W-1:0]      rem_re_next;
    logic [DVS_W-1:0]      rem_im_next;
    logic                  out_load;
    logic [SAMPLE_W-1:0]   res_re;
    logic [SAMPLE_W-1:0]   res_im;

    // Interior: full window inside the band, scale is a plain 2^-14.
    assign interior = (d_reg == h_reg) && (int'(j_reg) >= 2 * int'(h_reg));
    assign norm_pos = !norm_reg[NORM_W-1] && (norm_reg != '0);

    // Restoring division, one quotient bit per cycle for I and Q.
    assign rem_re_sh   = {rem_re_reg, num_re_reg[NUM_W-1]};
    assign rem_im_sh   = {rem_im_reg, num_im_reg[NUM_W-1]};
    assign re_ge       = rem_re_sh >= {1'b0, dvs_reg};
    assign im_ge       = rem_im_sh >= {1'b0, dvs_reg};
    assign rem_re_next = re_ge ? DVS_W'(rem_re_sh - {1'b0, dvs_reg}) : rem_re_sh[DVS_W-1:0];
    assign rem_im_next = im_ge ? DVS_W'(rem_im_sh - {1'b0, dvs_reg}) : rem_im_sh[DVS_W-1:0];

    assign res_re = use_pass_reg ? pass_reg[15:0]  : sat16(neg_re_reg, num_re_reg);
    assign res_im = use_pass_reg ? pass_reg[31:16] : sat16(neg_im_reg, num_im_reg);

    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            idx_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p1_cap_reg   <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // MAC pipeline: read issue, multiply, accumulate
            p1_valid_reg <= issue_ok;
            p1_cap_reg   <= cap_now;
            p1_tap_reg   <= tap_now;
            p2_valid_reg <= p1_valid_reg;
            p2_tap_reg   <= p1_tap_reg;
            p2_re_reg    <= p1_tap_reg * $signed(win_rdata_reg[15:0]);
            p2_im_reg    <= p1_tap_reg * $signed(win_rdata_reg[31:16]);
            if (p1_cap_reg) begin
                pass_reg <= win_rdata_reg;
            end
            if (p2_valid_reg) begin
                acc_re_reg <= acc_re_reg + ACC_W'(p2_re_reg);
                acc_im_reg <= acc_im_reg + ACC_W'(p2_im_reg);
                norm_reg   <= norm_reg + NORM_W'(p2_tap_reg);
            end

            // drop the held result once taken, unless a new one loads now
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        wp_reg     <= wp_next;
                        idx_reg    <= idx_next;
                        j_reg      <= idx_reg;
                        last_reg   <= s_tlast;
                        mtap_reg   <= m_eff;
                        h_reg      <= h_eff;
                        m_cnt_reg  <= '0;
                        acc_re_reg <= '0;
                        acc_im_reg <= '0;
                        norm_reg   <= '0;
                        // Flush starts at the oldest pending output
                        if (int'(idx_reg) >= int'(h_eff)) begin
                            d_reg     <= h_eff;
                            state_reg <= ST_MAC;
                        end else if (s_tlast) begin
                            d_reg     <= CNT_W'(idx_reg);
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_MAC: begin
                    m_cnt_reg <= m_cnt_reg + CNT_W'(1);
                    // last product lands in the accumulator on this edge
                    if (m_cnt_reg == mtap_reg + CNT_W'(1)) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    neg_re_reg <= acc_re_reg[ACC_W-1];
                    neg_im_reg <= acc_im_reg[ACC_W-1];
                    mag_re_reg <= acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
                    mag_im_reg <= acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
                    state_reg  <= ST_PREP;
                end
                ST_PREP: begin
                    if (interior) begin
                        num_re_reg   <= (NUM_W'(mag_re_reg) + NUM_W'(INT_ROUND)) >> FRAC_BITS;
                        num_im_reg   <= (NUM_W'(mag_im_reg) + NUM_W'(INT_ROUND)) >> FRAC_BITS;
                        use_pass_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end else if (norm_pos) begin
                        // round half away: (2|acc| + norm) / (2 norm)
                        num_re_reg   <= {mag_re_reg, 1'b0} + NUM_W'(norm_reg[NORM_W-2:0]);
                        num_im_reg   <= {mag_im_reg, 1'b0} + NUM_W'(norm_reg[NORM_W-2:0]);
                        dvs_reg      <= {norm_reg[NORM_W-2:0], 1'b0};
                        rem_re_reg   <= '0;
                        rem_im_reg   <= '0;
                        div_cnt_reg  <= '0;
                        use_pass_reg <= 1'b0;
                        state_reg    <= ST_DIV;
                    end else begin
                        use_pass_reg <= 1'b1;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_DIV: begin
                    rem_re_reg  <= rem_re_next;
                    rem_im_reg  <= rem_im_next;
                    num_re_reg  <= {num_re_reg[NUM_W-2:0], re_ge};
                    num_im_reg  <= {num_im_reg[NUM_W-2:0], im_ge};
                    div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
                    if (div_cnt_reg == DIVC_W'(NUM_W - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= {res_im, res_re};
                        m_last_reg   <= last_reg && (d_reg == '0);
                        if (last_reg && (d_reg != '0)) begin
                            // advance to the next flushed output
                            d_reg      <= d_reg - CNT_W'(1);
                            m_cnt_reg  <= '0;
                            acc_re_reg <= '0;
                            acc_im_reg <= '0;
                            norm_reg   <= '0;
                            state_reg  <= ST_MAC;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSER_ASSERT_NOW(a_no_result_overwrite, aclk, aresetn, out_load, !m_tvalid_reg || m_tready, "result register overwritten while held")
    `PSER_ASSERT_NOW(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, dvs_reg != '0, "edge divider running with zero divisor")
    `PSER_ASSERT_NEXT(a_band_rewind, aclk, aresetn, in_xfer && s_tlast, idx_reg == '0, "sample index not rewound after band end")

endmodule
